// ===== rtl/midpoint_circle_rasterizer_defines.svh =====
// -----------------------------------------------------------------------------
// midpoint_circle_rasterizer_defines.svh
// Assertion macros shared by the rasterizer RTL.
// -----------------------------------------------------------------------------
`ifndef MIDPOINT_CIRCLE_RASTERIZER_DEFINES_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define MCR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define MCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mcr_pkg.sv =====
// -----------------------------------------------------------------------------
// mcr_pkg
// Types and constants of the midpoint circle rasterizer.
// -----------------------------------------------------------------------------
package mcr_pkg;

	localparam int COORD_BITS = 10;
	localparam int OUT_BITS   = COORD_BITS + 2;
	localparam int ERR_BITS   = COORD_BITS + 3;
	localparam int COLOR_BITS = 8;
	localparam int CFG_IDX_BITS = 2;

	// command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_FG_RED   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FG_GREEN = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_FG_BLUE  = 2'd2;

	typedef struct packed {
		logic                  command;
		logic [COORD_BITS-1:0] center_x;
		logic [COORD_BITS-1:0] center_y;
		logic [COORD_BITS-1:0] radius;
		logic                  filled;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] pixel_x;
		logic signed [OUT_BITS-1:0] pixel_y;
		logic [COLOR_BITS-1:0]      red;
		logic [COLOR_BITS-1:0]      green;
		logic [COLOR_BITS-1:0]      blue;
		logic                       pixel_valid;
		logic                       last;
	} out_item_t;

	typedef struct packed {
		logic [COLOR_BITS-1:0] red;
		logic [COLOR_BITS-1:0] green;
		logic [COLOR_BITS-1:0] blue;
	} color_t;

	// figure state carried from one transaction to the next
	typedef struct packed {
		logic [COORD_BITS-1:0]      centre_col;
		logic [COORD_BITS-1:0]      centre_row;
		logic signed [COORD_BITS:0] major_offset;
		logic signed [COORD_BITS:0] minor_offset;
		logic signed [ERR_BITS-1:0] decision_error;
		logic [2:0]                 octant_index;
		logic [COORD_BITS-1:0]      circle_size;
		logic                       fill_mode;
		logic                       active;
	} fig_state_t;

endpackage

// ===== rtl/mcr_step.sv =====
// -----------------------------------------------------------------------------
// mcr_step
// One rasterizer step: from the current figure state and one input
// transaction, the next state and the result transaction.
// -----------------------------------------------------------------------------
module mcr_step (
	input  mcr_pkg::in_item_t   item,
	input  mcr_pkg::fig_state_t st,
	input  mcr_pkg::color_t     color,
	output mcr_pkg::fig_state_t st_nxt,
	output mcr_pkg::out_item_t  res
);

	localparam int CB = mcr_pkg::COORD_BITS;
	localparam int OB = mcr_pkg::OUT_BITS;
	localparam int EB = mcr_pkg::ERR_BITS;
	localparam int MB = CB + 1;
	localparam int W  = CB + 4;

	localparam logic [2:0] OCT_XY   = 3'd0;
	localparam logic [2:0] OCT_YX   = 3'd1;
	localparam logic [2:0] OCT_NXY  = 3'd2;
	localparam logic [2:0] OCT_NYX  = 3'd3;
	localparam logic [2:0] OCT_NXNY = 3'd4;
	localparam logic [2:0] OCT_NYNX = 3'd5;
	localparam logic [2:0] OCT_XNY  = 3'd6;
	localparam logic [2:0] OCT_YNX  = 3'd7;

	logic [CB-1:0]        start_r;
	logic [CB-1:0]        next_r;
	logic signed [OB-1:0] x_w;
	logic signed [OB-1:0] y_w;
	logic signed [OB-1:0] dx;
	logic signed [OB-1:0] dy;
	logic signed [W-1:0]  x1;
	logic signed [W-1:0]  y1;
	logic signed [W-1:0]  err1;
	logic                 fin;

	assign start_r = item.filled ? (item.radius - CB'(1)) : item.radius;
	assign next_r  = st.circle_size - CB'(1);

	assign x_w = OB'(st.major_offset);
	assign y_w = OB'(st.minor_offset);

	always_comb begin
		unique case (st.octant_index)
			OCT_XY:   begin dx = x_w;  dy = y_w;  end
			OCT_YX:   begin dx = y_w;  dy = x_w;  end
			OCT_NXY:  begin dx = -x_w; dy = y_w;  end
			OCT_NYX:  begin dx = -y_w; dy = x_w;  end
			OCT_NXNY: begin dx = -x_w; dy = -y_w; end
			OCT_NYNX: begin dx = -y_w; dy = -x_w; end
			OCT_XNY:  begin dx = x_w;  dy = -y_w; end
			OCT_YNX:  begin dx = y_w;  dy = -x_w; end
		endcase
	end

	// midpoint update at the end of an iteration
	always_comb begin
		y1 = W'(st.minor_offset) + W'(1);
		if (st.decision_error < 0) begin
			x1   = W'(st.major_offset);
			err1 = W'(st.decision_error) + (y1 <<< 1) + W'(1);
		end else begin
			x1   = W'(st.major_offset) - W'(1);
			err1 = W'(st.decision_error) + ((y1 - x1 + W'(1)) <<< 1);
		end
	end

	always_comb begin
		st_nxt = st;
		res    = '0;
		fin    = 1'b0;
		if (item.command == mcr_pkg::CMD_START) begin
			st_nxt.centre_col = item.center_x;
			st_nxt.centre_row = item.center_y;
			st_nxt.fill_mode  = item.filled;
			if (item.filled && (item.radius == '0)) begin
				st_nxt.active = 1'b0;
			end else begin
				st_nxt.circle_size    = start_r;
				st_nxt.major_offset   = MB'({1'b0, start_r});
				st_nxt.minor_offset   = '0;
				st_nxt.decision_error = EB'(1) - EB'({1'b0, start_r});
				st_nxt.octant_index   = OCT_XY;
				st_nxt.active         = 1'b1;
			end
		end else if (st.active) begin
			if (st.octant_index == OCT_YNX) begin
				st_nxt.octant_index   = OCT_XY;
				st_nxt.major_offset   = MB'(x1);
				st_nxt.minor_offset   = MB'(y1);
				st_nxt.decision_error = EB'(err1);
				if (x1 < y1) begin
					if (st.fill_mode && (st.circle_size != '0)) begin
						// drop to the next smaller concentric circle
						st_nxt.circle_size    = next_r;
						st_nxt.major_offset   = MB'({1'b0, next_r});
						st_nxt.minor_offset   = '0;
						st_nxt.decision_error = EB'(1) - EB'({1'b0, next_r});
					end else begin
						st_nxt.active = 1'b0;
						fin           = 1'b1;
					end
				end
			end else begin
				st_nxt.octant_index = st.octant_index + 3'd1;
			end
			res.pixel_x     = OB'({2'b00, st.centre_col}) + dx;
			res.pixel_y     = OB'({2'b00, st.centre_row}) + dy;
			res.red         = color.red;
			res.green       = color.green;
			res.blue        = color.blue;
			res.pixel_valid = 1'b1;
			res.last        = fin;
		end
	end

endmodule

// ===== rtl/midpoint_circle_rasterizer.sv =====
// -----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// Midpoint circle pixel generator with outline and filled modes.
// -----------------------------------------------------------------------------
// Every input transaction yields exactly one result transaction: a start
// returns an empty result (pixel_valid low), each tick returns the next pixel
// of an active figure, eight octant points per iteration (an empty result
// once the figure is done), and last marks the final pixel. The block accepts
// one transaction per clock while the input is not stalled. An accepted
// transaction is held in the input register, its result in the output
// register. The input stalls only while both registers hold a transaction and
// the output is stalled. The figure state (offsets, decision error, octant) is
// updated once per transaction by the step logic between those two registers.
// Color registers are sampled when a tick is processed.
// -----------------------------------------------------------------------------
`include "midpoint_circle_rasterizer_defines.svh"

module midpoint_circle_rasterizer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  mcr_pkg::in_item_t                    in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output mcr_pkg::out_item_t                   out_data,
	input  logic                                 cfg_we,
	input  logic [mcr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [mcr_pkg::COLOR_BITS-1:0]       cfg_data
);

	logic                v_s1;
	mcr_pkg::in_item_t   item_s1;
	logic                v_s2;
	mcr_pkg::out_item_t  res_s2;
	mcr_pkg::fig_state_t st_q;
	mcr_pkg::fig_state_t st_nxt;
	mcr_pkg::out_item_t  res;
	mcr_pkg::color_t     color_q;
	logic                accept;
	logic                adv;

	assign adv      = v_s1 && (!v_s2 || !out_stall);
	assign in_stall = v_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	mcr_step u_step (
		.item   (item_s1),
		.st     (st_q),
		.color  (color_q),
		.st_nxt (st_nxt),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			st_q    <= '0;
			color_q <= '0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				v_s2 <= 1'b1;
				st_q <= st_nxt;
			end else if (!out_stall) begin
				v_s2 <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					mcr_pkg::REG_FG_RED:   color_q.red   <= cfg_data;
					mcr_pkg::REG_FG_GREEN: color_q.green <= cfg_data;
					mcr_pkg::REG_FG_BLUE:  color_q.blue  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = res_s2;

	`MCR_ASSERT_IMPLY(a_stall_needs_item, clk, arst_n, in_stall, v_s1 && v_s2 && out_stall,
		"input stalled without a blocked transaction")
	`MCR_ASSERT_NEXT(a_s1_held, clk, arst_n, v_s1 && in_stall, v_s1 && $stable(item_s1),
		"input register lost a stalled transaction")
	`MCR_ASSERT_IMPLY(a_blank_result, clk, arst_n, v_s2 && !res_s2.pixel_valid,
		res_s2.pixel_x == '0 && res_s2.pixel_y == '0 && res_s2.red == '0 &&
		res_s2.green == '0 && res_s2.blue == '0 && !res_s2.last,
		"empty result carries nonzero fields")
	`MCR_ASSERT_IMPLY(a_last_is_pixel, clk, arst_n, v_s2 && res_s2.last, res_s2.pixel_valid,
		"last flag on a result without a pixel")

endmodule
